/* sv/s2hfn_pkg.sv */
// Shared types, codes and the fixed key tables for the scan code to HID
// translator with Fn layer. No dependencies.
package s2hfn_pkg;

    localparam int SLOT_W   = 7;
    localparam int CODE_W   = 8;
    localparam int VALUE_W  = 16;
    localparam int ACTION_W = 2;

    // keyboard ID bytes, dropped without effect
    localparam logic [CODE_W-1:0] ID_BYTE_A = 8'hFA;
    localparam logic [CODE_W-1:0] ID_BYTE_B = 8'hFD;

    localparam logic [SLOT_W-1:0] FN_SLOT_RESET = 7'h22;

    localparam logic [ACTION_W-1:0] ACT_PRESS       = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RELEASE     = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RELEASE_ALL = 2'd2;

    typedef struct packed {
        logic                valid;
        logic [ACTION_W-1:0] action;
        logic [VALUE_W-1:0]  key_value;
    } t_xlate_res;

    // base layer: low byte usage id, high byte modifier mask
    function automatic logic [VALUE_W-1:0] base_value(input logic [SLOT_W-1:0] slot);
        logic [VALUE_W-1:0] v;
        case (slot)
            7'd0:  v = 16'h001e;
            7'd1:  v = 16'h001f;
            7'd2:  v = 16'h0020;
            7'd3:  v = 16'h001d;
            7'd4:  v = 16'h0021;
            7'd5:  v = 16'h0022;
            7'd6:  v = 16'h0023;
            7'd7:  v = 16'h0024;
            7'd8:  v = 16'h0800;
            7'd9:  v = 16'h0014;
            7'd10: v = 16'h001a;
            7'd11: v = 16'h0008;
            7'd12: v = 16'h0015;
            7'd13: v = 16'h0017;
            7'd14: v = 16'h001c;
            7'd15: v = 16'h0035;
            7'd16: v = 16'h001b;
            7'd17: v = 16'h0004;
            7'd18: v = 16'h0016;
            7'd19: v = 16'h0007;
            7'd20: v = 16'h0009;
            7'd21: v = 16'h000a;
            7'd22: v = 16'h000b;
            7'd23: v = 16'h002c;
            7'd24: v = 16'h0039;
            7'd25: v = 16'h002b;
            7'd26: v = 16'h0100;
            7'd35: v = 16'h0400;
            7'd44: v = 16'h0006;
            7'd45: v = 16'h0019;
            7'd46: v = 16'h0005;
            7'd47: v = 16'h0011;
            7'd48: v = 16'h002d;
            7'd49: v = 16'h002e;
            7'd50: v = 16'h002a;
            7'd51: v = 16'h004a;
            7'd52: v = 16'h0025;
            7'd53: v = 16'h0026;
            7'd54: v = 16'h0027;
            7'd55: v = 16'h4000;
            7'd56: v = 16'h002f;
            7'd57: v = 16'h0030;
            7'd58: v = 16'h0031;
            7'd59: v = 16'h004d;
            7'd60: v = 16'h0018;
            7'd61: v = 16'h000c;
            7'd62: v = 16'h0012;
            7'd63: v = 16'h0013;
            7'd64: v = 16'h0034;
            7'd65: v = 16'h0028;
            7'd66: v = 16'h004b;
            7'd68: v = 16'h000d;
            7'd69: v = 16'h000e;
            7'd70: v = 16'h000f;
            7'd71: v = 16'h0033;
            7'd72: v = 16'h0038;
            7'd73: v = 16'h0052;
            7'd74: v = 16'h004e;
            7'd76: v = 16'h0010;
            7'd77: v = 16'h0036;
            7'd78: v = 16'h0037;
            7'd79: v = 16'h0049;
            7'd80: v = 16'h1000;
            7'd81: v = 16'h0050;
            7'd82: v = 16'h0051;
            7'd83: v = 16'h004f;
            7'd88: v = 16'h0200;
            7'd89: v = 16'h2000;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

    // Fn layer: zero means no override
    function automatic logic [VALUE_W-1:0] fn_value(input logic [SLOT_W-1:0] slot);
        logic [VALUE_W-1:0] v;
        case (slot)
            7'd0:  v = 16'h003a;
            7'd1:  v = 16'h003b;
            7'd2:  v = 16'h003c;
            7'd4:  v = 16'h003d;
            7'd5:  v = 16'h003e;
            7'd6:  v = 16'h003f;
            7'd7:  v = 16'h0040;
            7'd25: v = 16'h0029;
            7'd48: v = 16'h0044;
            7'd49: v = 16'h0045;
            7'd50: v = 16'h004c;
            7'd52: v = 16'h0041;
            7'd53: v = 16'h0042;
            7'd54: v = 16'h0043;
            7'd79: v = 16'h0046;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

endpackage

/* sv/s2hfn_core.sv */
// Translation step: table lookup, Fn layer and key state (Fn held, last
// release byte, per-slot Fn marks). Depends on s2hfn_pkg.
module s2hfn_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [s2hfn_pkg::CODE_W-1:0]  i_code,
    input  logic [s2hfn_pkg::SLOT_W-1:0]  i_fn_slot,
    output s2hfn_pkg::t_xlate_res         o_res
);

    localparam int SLOTS = 2 ** s2hfn_pkg::SLOT_W;

    logic [s2hfn_pkg::CODE_W-1:0] r_prev_rel, n_prev_rel;
    logic                         r_fn_held, n_fn_held;
    logic [SLOTS-1:0]             r_fn_marked, n_fn_marked;

    logic [s2hfn_pkg::SLOT_W-1:0]  slot;
    logic [s2hfn_pkg::VALUE_W-1:0] base_v, fn_v;
    logic                          is_id, is_rel, is_fn;

    always_comb begin
        slot   = i_code[s2hfn_pkg::SLOT_W-1:0];
        is_rel = i_code[s2hfn_pkg::CODE_W-1];
        is_id  = (i_code == s2hfn_pkg::ID_BYTE_A) || (i_code == s2hfn_pkg::ID_BYTE_B);
        is_fn  = (slot == i_fn_slot);
        base_v = s2hfn_pkg::base_value(slot);
        fn_v   = s2hfn_pkg::fn_value(slot);

        n_prev_rel  = r_prev_rel;
        n_fn_held   = r_fn_held;
        n_fn_marked = r_fn_marked;
        o_res       = '0;

        if (!is_id) begin
            if (is_rel) begin
                if (r_prev_rel == i_code) begin
                    // same release byte twice: drop everything
                    n_prev_rel      = '0;
                    n_fn_held       = 1'b0;
                    n_fn_marked     = '0;
                    o_res.valid     = 1'b1;
                    o_res.action    = s2hfn_pkg::ACT_RELEASE_ALL;
                    o_res.key_value = '0;
                end else begin
                    n_prev_rel = i_code;
                    if (is_fn) begin
                        n_fn_held = 1'b0;
                    end else begin
                        o_res.valid     = 1'b1;
                        o_res.action    = s2hfn_pkg::ACT_RELEASE;
                        o_res.key_value = r_fn_marked[slot] ? fn_v : base_v;
                        n_fn_marked[slot] = 1'b0;
                    end
                end
            end else begin
                n_prev_rel = '0;
                if (is_fn) begin
                    n_fn_held = 1'b1;
                end else begin
                    o_res.valid     = 1'b1;
                    o_res.action    = s2hfn_pkg::ACT_PRESS;
                    o_res.key_value = base_v;
                    if (r_fn_held && (fn_v != '0)) begin
                        o_res.key_value   = fn_v;
                        n_fn_marked[slot] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_rel  <= '0;
            r_fn_held   <= 1'b0;
            r_fn_marked <= '0;
        end else if (i_fire) begin
            r_prev_rel  <= n_prev_rel;
            r_fn_held   <= n_fn_held;
            r_fn_marked <= n_fn_marked;
        end
    end

endmodule

/* sv/scancode_to_hid_fn_layer.sv */
// Top level of the scan code to HID translator with Fn layer.
// Depends on s2hfn_pkg and s2hfn_core.
//
// Takes one scan byte per clock on the slave stream while no stalled result on
// the master stream holds it off, and gives at most one key action per byte
// (tuser = action, tdata = key value). A byte passes an input register, then
// the lookup and state update, then the result register. ID bytes, Fn presses
// and Fn releases give no transfer. The Fn slot register resets to 0x22 and is
// written through the cfg channel, always ready; the user must write it only
// while the stream is idle, as the block itself does not enforce this.
module scancode_to_hid_fn_layer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] scan_code
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [15:0]                     m_axis_tdata,  // [15:0] key_value
    output logic [1:0]                      m_axis_tuser,  // [1:0] action
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [6:0]                      i_cfg_data     // fn_slot
);

    logic [s2hfn_pkg::SLOT_W-1:0]   r_fn_slot;
    logic                           r_in_valid;
    logic [s2hfn_pkg::CODE_W-1:0]   r_code;
    logic                           r_out_valid;
    logic [s2hfn_pkg::ACTION_W-1:0] r_action;
    logic [s2hfn_pkg::VALUE_W-1:0]  r_key_value;

    s2hfn_pkg::t_xlate_res          res;
    logic                           advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_key_value;
    assign m_axis_tuser  = r_action;

    s2hfn_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (advance),
        .i_code    (r_code),
        .i_fn_slot (r_fn_slot),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fn_slot <= s2hfn_pkg::FN_SLOT_RESET;
        end else if (i_cfg_valid) begin
            r_fn_slot <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_code <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res.valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.valid) begin
            r_action    <= res.action;
            r_key_value <= res.key_value;
        end
    end

endmodule

/* sv/s2hfn_checker.sv */
// Port-level checks for scancode_to_hid_fn_layer, bound to the top level.
// Depends on s2hfn_pkg.
module s2hfn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // stalled transfer keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    a_action_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == s2hfn_pkg::ACT_PRESS) ||
                          (m_axis_tuser == s2hfn_pkg::ACT_RELEASE) ||
                          (m_axis_tuser == s2hfn_pkg::ACT_RELEASE_ALL))
        else $error("undefined action code");

    a_rel_all_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == s2hfn_pkg::ACT_RELEASE_ALL) |->
            (m_axis_tdata == 16'h0000))
        else $error("release-all with nonzero key value");

    // input only holds off behind a stalled result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with the output free");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid straight after reset");

endmodule

bind scancode_to_hid_fn_layer s2hfn_checker u_s2hfn_checker (.*);
